>>> rtl/mcfe_pkg.sv
package mcfe_pkg;

    // field and register widths
    localparam int SMP_W     = 16;
    localparam int BUS_W     = 26;
    localparam int WORK_W    = 24;
    localparam int FREQ_W    = 37;
    localparam int CYC_W     = 32;

    // apb port
    localparam int ADDR_W    = 3;
    localparam int DATA_W    = 32;

    // register indexes, taken from paddr[2]
    localparam logic REG_BUS_HZ = 1'b0;
    localparam logic REG_WORK   = 1'b1;

    // operation codes
    localparam logic OP_SAMPLE  = 1'b0;
    localparam logic OP_CONVERT = 1'b1;

    // reset values
    localparam logic [BUS_W-1:0]  BUS_HZ_RST = BUS_W'(7093790);
    localparam logic [WORK_W-1:0] WORK_RST   = WORK_W'(131072);
    localparam logic [FREQ_W-1:0] FREQ_RST   = FREQ_W'(50000000);

    localparam int NUM_SAMPLES_DEF = 8;

    // arithmetic
    localparam int CAL_MUL   = 19;     // 0.95 folded in: 2 / (19 * elapsed)
    localparam int MS_MUL    = 1000;
    localparam int DEN_W     = 21;     // 19 * 65535
    localparam int WB_W      = WORK_W + BUS_W;
    localparam int W1000_W   = 34;
    localparam int T10_W     = SMP_W + 4;
    localparam int FREQ_LO_W = 19;
    localparam int PPL_W     = T10_W + FREQ_LO_W;
    localparam int PPH_W     = T10_W + FREQ_W - FREQ_LO_W;
    localparam int DVD_W     = T10_W + FREQ_W;
    localparam int DVS_W     = BUS_W;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SORT,
        S_MUL,
        S_SUM,
        S_DIV,
        S_RESULT
    } t_state;

    typedef struct packed {
        logic capture;
        logic sort_step;
        logic mul;
        logic div_start;
        logic load;
    } t_cmd;

    typedef struct packed {
        logic last_sample;
        logic sort_last;
        logic div_busy;
        logic out_free;
    } t_status;

endpackage

>>> rtl/mcfe_in_if.sv
interface mcfe_in_if;
    logic                       valid;
    logic                       ready;
    logic                       op;
    logic [mcfe_pkg::SMP_W-1:0] count;

    modport source (output valid, output op, output count, input ready);
    modport sink   (input valid, input op, input count, output ready);
endinterface

>>> rtl/mcfe_out_if.sv
interface mcfe_out_if;
    logic                        valid;
    logic                        ready;
    logic                        calibration_done;
    logic [mcfe_pkg::FREQ_W-1:0] freq_hz;
    logic [mcfe_pkg::CYC_W-1:0]  cycles;
    logic                        calibrated;

    modport source (output valid, output calibration_done, output freq_hz, output cycles,
                    output calibrated, input ready);
    modport sink   (input valid, input calibration_done, input freq_hz, input cycles,
                    input calibrated, output ready);
endinterface

>>> rtl/median_clock_frequency_estimator_core.sv
// one item at a time; a sample that does not complete a set goes straight to the result state
// a convert goes through the multiply, sum, divide and result states; a sample completing a set
// sorts first and then takes the same path through the 57-step restoring divider
// a new item is taken while the previous result still waits in the output register
// synchronous active-low reset: sample count and calibrated flag cleared, estimate set to 50 MHz,
// registers back to defaults; the sample store holds no reset value and is filled before use
module median_clock_frequency_estimator_core #(
    parameter int NUM_SAMPLES = mcfe_pkg::NUM_SAMPLES_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [mcfe_pkg::ADDR_W-1:0]   paddr,
    input  logic [mcfe_pkg::DATA_W-1:0]   pwdata,
    output logic [mcfe_pkg::DATA_W-1:0]   prdata,
    output logic                          pready,
    mcfe_in_if.sink                       i_in,
    mcfe_out_if.source                    o_out
);

    logic [mcfe_pkg::BUS_W-1:0]  bus_hz;
    logic [mcfe_pkg::WORK_W-1:0] work;
    mcfe_pkg::t_cmd              cmd;
    mcfe_pkg::t_status           status;
    logic                        in_ready;
    logic                        out_valid;
    logic                        out_done;
    logic [mcfe_pkg::FREQ_W-1:0] out_freq;
    logic [mcfe_pkg::CYC_W-1:0]  out_cyc;
    logic                        out_cal;

    mcfe_cfg u_cfg (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .o_bus_hz (bus_hz),
        .o_work   (work)
    );

    mcfe_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .i_in_op    (i_in.op),
        .o_in_ready (in_ready),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    mcfe_dp #(
        .NUM_SAMPLES (NUM_SAMPLES)
    ) u_dp (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cmd              (cmd),
        .o_status           (status),
        .i_op               (i_in.op),
        .i_count            (i_in.count),
        .i_bus_hz           (bus_hz),
        .i_work             (work),
        .i_out_ready        (o_out.ready),
        .o_out_valid        (out_valid),
        .o_calibration_done (out_done),
        .o_freq_hz          (out_freq),
        .o_cycles           (out_cyc),
        .o_calibrated       (out_cal)
    );

    assign i_in.ready             = in_ready;
    assign o_out.valid            = out_valid;
    assign o_out.calibration_done = out_done;
    assign o_out.freq_hz          = out_freq;
    assign o_out.cycles           = out_cyc;
    assign o_out.calibrated       = out_cal;

endmodule

>>> rtl/mcfe_cfg.sv
module mcfe_cfg (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [mcfe_pkg::ADDR_W-1:0]   paddr,
    input  logic [mcfe_pkg::DATA_W-1:0]   pwdata,
    output logic [mcfe_pkg::DATA_W-1:0]   prdata,
    output logic                          pready,
    output logic [mcfe_pkg::BUS_W-1:0]    o_bus_hz,
    output logic [mcfe_pkg::WORK_W-1:0]   o_work
);

    logic [mcfe_pkg::BUS_W-1:0]  r_bus_hz;
    logic [mcfe_pkg::WORK_W-1:0] r_work;
    logic                        wr_en;

    assign wr_en  = psel && penable && pwrite;
    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bus_hz <= mcfe_pkg::BUS_HZ_RST;
            r_work   <= mcfe_pkg::WORK_RST;
        end else if (wr_en) begin
            case (paddr[2])
                mcfe_pkg::REG_BUS_HZ: r_bus_hz <= pwdata[mcfe_pkg::BUS_W-1:0];
                mcfe_pkg::REG_WORK:   r_work   <= pwdata[mcfe_pkg::WORK_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[2])
            mcfe_pkg::REG_BUS_HZ: prdata = mcfe_pkg::DATA_W'(r_bus_hz);
            mcfe_pkg::REG_WORK:   prdata = mcfe_pkg::DATA_W'(r_work);
            default:              prdata = '0;
        endcase
    end

    assign o_bus_hz = r_bus_hz;
    assign o_work   = r_work;

endmodule

>>> rtl/mcfe_div.sv
module mcfe_div (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_start,
    input  logic [mcfe_pkg::DVD_W-1:0]   i_dividend,
    input  logic [mcfe_pkg::DVS_W-1:0]   i_divisor,
    output logic                         o_busy,
    output logic [mcfe_pkg::DVD_W-1:0]   o_quotient
);

    localparam int CNT_W = $clog2(mcfe_pkg::DVD_W + 1);

    logic [CNT_W-1:0]             r_cnt;
    logic                         r_busy;
    logic [mcfe_pkg::DVD_W-1:0]   r_quo;
    logic [mcfe_pkg::DVS_W-1:0]   r_rem;
    logic [mcfe_pkg::DVS_W-1:0]   r_dvs;
    logic [mcfe_pkg::DVS_W:0]     rem_sh;
    logic [mcfe_pkg::DVS_W:0]     diff;
    logic                         geq;

    // one restoring step per cycle, dividend bits shift out as quotient bits shift in
    assign rem_sh = {r_rem, r_quo[mcfe_pkg::DVD_W-1]};
    assign geq    = rem_sh >= {1'b0, r_dvs};
    assign diff   = rem_sh - {1'b0, r_dvs};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= CNT_W'(mcfe_pkg::DVD_W);
        end else if (r_busy) begin
            r_cnt <= r_cnt - CNT_W'(1);
            if (r_cnt == CNT_W'(1)) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_dividend;
            r_rem <= '0;
            r_dvs <= i_divisor;
        end else if (r_busy) begin
            r_quo <= {r_quo[mcfe_pkg::DVD_W-2:0], geq};
            r_rem <= geq ? diff[mcfe_pkg::DVS_W-1:0] : rem_sh[mcfe_pkg::DVS_W-1:0];
        end
    end

    assign o_busy     = r_busy;
    assign o_quotient = r_quo;

endmodule

>>> rtl/mcfe_dp.sv
module mcfe_dp #(
    parameter int NUM_SAMPLES = mcfe_pkg::NUM_SAMPLES_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  mcfe_pkg::t_cmd                i_cmd,
    output mcfe_pkg::t_status             o_status,
    input  logic                          i_op,
    input  logic [mcfe_pkg::SMP_W-1:0]    i_count,
    input  logic [mcfe_pkg::BUS_W-1:0]    i_bus_hz,
    input  logic [mcfe_pkg::WORK_W-1:0]   i_work,
    input  logic                          i_out_ready,
    output logic                          o_out_valid,
    output logic                          o_calibration_done,
    output logic [mcfe_pkg::FREQ_W-1:0]   o_freq_hz,
    output logic [mcfe_pkg::CYC_W-1:0]    o_cycles,
    output logic                          o_calibrated
);

    localparam int IDX_W = $clog2(NUM_SAMPLES);
    localparam int MED   = NUM_SAMPLES / 2;

    // sample store and odd-even transposition sorter
    logic [mcfe_pkg::SMP_W-1:0] r_smp [NUM_SAMPLES];
    logic [mcfe_pkg::SMP_W-1:0] n_smp [NUM_SAMPLES];
    logic [IDX_W-1:0]           r_sample_count;
    logic [IDX_W-1:0]           r_sort_cnt;

    // per item
    logic                         r_op;
    logic                         r_calib;
    logic [mcfe_pkg::SMP_W-1:0]   r_count;

    // product stage
    logic [mcfe_pkg::WB_W-1:0]    r_wb;
    logic [mcfe_pkg::DEN_W-1:0]   r_den;
    logic [mcfe_pkg::W1000_W-1:0] r_w1000;
    logic                         r_med_zero;
    logic [mcfe_pkg::PPL_W-1:0]   r_pp_lo;
    logic [mcfe_pkg::PPH_W-1:0]   r_pp_hi;
    logic [mcfe_pkg::T10_W-1:0]   t10;
    logic                         r_num_zero;

    // divider
    logic [mcfe_pkg::DVD_W-1:0]   dvd;
    logic [mcfe_pkg::DVS_W-1:0]   dvs;
    logic                         div_busy;
    logic [mcfe_pkg::DVD_W-1:0]   quo;

    // estimate state and output stage
    logic [mcfe_pkg::FREQ_W-1:0]  r_cpu_freq;
    logic                         r_calibrated;
    logic [mcfe_pkg::FREQ_W-1:0]  freq_sat;
    logic [mcfe_pkg::FREQ_W-1:0]  freq_new;
    logic [mcfe_pkg::CYC_W-1:0]   cyc_val;
    logic                         r_out_valid;
    logic                         r_out_done;
    logic [mcfe_pkg::FREQ_W-1:0]  r_out_freq;
    logic [mcfe_pkg::CYC_W-1:0]   r_out_cyc;
    logic                         r_out_cal;

    always_comb begin
        n_smp = r_smp;
        for (int k = 0; k + 1 < NUM_SAMPLES; k++) begin
            if ((k[0] == r_sort_cnt[0]) && (r_smp[k] > r_smp[k+1])) begin
                n_smp[k]   = r_smp[k+1];
                n_smp[k+1] = r_smp[k];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture && !i_op) begin
            r_smp[r_sample_count] <= ~i_count;
        end else if (i_cmd.sort_step) begin
            r_smp <= n_smp;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sample_count <= '0;
            r_sort_cnt     <= '0;
        end else if (i_cmd.capture) begin
            r_sort_cnt <= '0;
            if (!i_op) begin
                r_sample_count <= o_status.last_sample ? '0 : r_sample_count + IDX_W'(1);
            end
        end else if (i_cmd.sort_step) begin
            r_sort_cnt <= r_sort_cnt + IDX_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_op    <= i_op;
            r_calib <= !i_op && o_status.last_sample;
            r_count <= i_count;
        end
    end

    // ticks * 10
    assign t10 = mcfe_pkg::T10_W'({r_count, 3'b000}) + mcfe_pkg::T10_W'({r_count, 1'b0});

    always_ff @(posedge i_clk) begin
        if (i_cmd.mul) begin
            r_wb       <= mcfe_pkg::WB_W'(i_work) * mcfe_pkg::WB_W'(i_bus_hz);
            r_den      <= mcfe_pkg::DEN_W'(r_smp[MED]) * mcfe_pkg::DEN_W'(mcfe_pkg::CAL_MUL);
            r_w1000    <= mcfe_pkg::W1000_W'(i_work) * mcfe_pkg::W1000_W'(mcfe_pkg::MS_MUL);
            r_med_zero <= r_smp[MED] == '0;
            r_pp_lo    <= mcfe_pkg::PPL_W'(t10)
                        * mcfe_pkg::PPL_W'(r_cpu_freq[mcfe_pkg::FREQ_LO_W-1:0]);
            r_pp_hi    <= mcfe_pkg::PPH_W'(t10)
                        * mcfe_pkg::PPH_W'(r_cpu_freq[mcfe_pkg::FREQ_W-1:mcfe_pkg::FREQ_LO_W]);
        end
    end

    // calibration: work * bus * 2 / (19 * median); convert: ticks * 10 * freq / bus
    assign dvd = r_op ? mcfe_pkg::DVD_W'(r_pp_lo)
                        + (mcfe_pkg::DVD_W'(r_pp_hi) << mcfe_pkg::FREQ_LO_W)
                      : mcfe_pkg::DVD_W'({r_wb, 1'b0});
    assign dvs = r_op ? i_bus_hz : mcfe_pkg::DVS_W'(r_den);

    always_ff @(posedge i_clk) begin
        if (i_cmd.div_start) begin
            r_num_zero <= dvd == '0;
        end
    end

    mcfe_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_start),
        .i_dividend (dvd),
        .i_divisor  (dvs),
        .o_busy     (div_busy),
        .o_quotient (quo)
    );

    assign freq_sat = (|quo[mcfe_pkg::DVD_W-1:mcfe_pkg::FREQ_W]) ? '1
                                                                 : quo[mcfe_pkg::FREQ_W-1:0];
    // zero median means 1 ms without the 0.95 factor
    assign freq_new = r_med_zero ? mcfe_pkg::FREQ_W'(r_w1000) : freq_sat;

    always_comb begin
        if (!r_op || r_num_zero) begin
            cyc_val = '0;
        end else if (|quo[mcfe_pkg::DVD_W-1:mcfe_pkg::CYC_W]) begin
            cyc_val = '1;
        end else begin
            cyc_val = quo[mcfe_pkg::CYC_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cpu_freq   <= mcfe_pkg::FREQ_RST;
            r_calibrated <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            if (i_cmd.load) begin
                r_out_valid <= 1'b1;
                if (r_calib) begin
                    r_cpu_freq   <= freq_new;
                    r_calibrated <= 1'b1;
                end
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_out_done <= r_calib;
            r_out_freq <= r_calib ? freq_new : r_cpu_freq;
            r_out_cyc  <= cyc_val;
            r_out_cal  <= r_calib || r_calibrated;
        end
    end

    assign o_status.last_sample = r_sample_count == IDX_W'(NUM_SAMPLES - 1);
    assign o_status.sort_last   = r_sort_cnt == IDX_W'(NUM_SAMPLES - 1);
    assign o_status.div_busy    = div_busy;
    assign o_status.out_free    = !r_out_valid || i_out_ready;

    assign o_out_valid        = r_out_valid;
    assign o_calibration_done = r_out_done;
    assign o_freq_hz          = r_out_freq;
    assign o_cycles           = r_out_cyc;
    assign o_calibrated       = r_out_cal;

endmodule

>>> rtl/mcfe_ctrl.sv
module mcfe_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  logic               i_in_op,
    output logic               o_in_ready,
    input  mcfe_pkg::t_status  i_status,
    output mcfe_pkg::t_cmd     o_cmd
);

    mcfe_pkg::t_state r_state;
    mcfe_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= mcfe_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            mcfe_pkg::S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.capture = 1'b1;
                    if (i_in_op) begin
                        n_state = mcfe_pkg::S_MUL;
                    end else if (i_status.last_sample) begin
                        n_state = mcfe_pkg::S_SORT;
                    end else begin
                        n_state = mcfe_pkg::S_RESULT;
                    end
                end
            end
            mcfe_pkg::S_SORT: begin
                o_cmd.sort_step = 1'b1;
                if (i_status.sort_last) begin
                    n_state = mcfe_pkg::S_MUL;
                end
            end
            mcfe_pkg::S_MUL: begin
                o_cmd.mul = 1'b1;
                n_state   = mcfe_pkg::S_SUM;
            end
            mcfe_pkg::S_SUM: begin
                o_cmd.div_start = 1'b1;
                n_state         = mcfe_pkg::S_DIV;
            end
            mcfe_pkg::S_DIV: begin
                if (!i_status.div_busy) begin
                    n_state = mcfe_pkg::S_RESULT;
                end
            end
            mcfe_pkg::S_RESULT: begin
                if (i_status.out_free) begin
                    o_cmd.load = 1'b1;
                    n_state    = mcfe_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = mcfe_pkg::S_IDLE;
            end
        endcase
    end

endmodule

>>> rtl/mcfe_chk.sv
module mcfe_chk (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          i_in_valid,
    input logic                          i_in_ready,
    input logic                          i_out_valid,
    input logic                          i_out_ready,
    input logic                          i_out_done,
    input logic [mcfe_pkg::FREQ_W-1:0]   i_out_freq,
    input logic [mcfe_pkg::CYC_W-1:0]    i_out_cycles,
    input logic                          i_out_cal
);

    logic [1:0]                  r_pending;
    logic                        r_seen_cal;
    logic [mcfe_pkg::FREQ_W-1:0] r_last_freq;
    logic                        in_acc;
    logic                        out_acc;

    assign in_acc  = i_in_valid && i_in_ready;
    assign out_acc = i_out_valid && i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pending   <= '0;
            r_seen_cal  <= 1'b0;
            r_last_freq <= mcfe_pkg::FREQ_RST;
        end else begin
            r_pending <= r_pending + 2'(in_acc) - 2'(out_acc);
            if (out_acc) begin
                r_seen_cal  <= r_seen_cal || i_out_cal;
                r_last_freq <= i_out_freq;
            end
        end
    end

    // a completed calibration is reported as calibrated
    a_done_cal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_done |-> i_out_cal)
        else $error("calibration_done without calibrated");

    // calibrated never drops once delivered
    a_cal_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && r_seen_cal |-> i_out_cal)
        else $error("calibrated flag dropped");

    // the estimate only moves on a result that completes a calibration
    a_freq_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_done |-> i_out_freq == r_last_freq)
        else $error("frequency changed without calibration");

    // at most one item in work plus one waiting result, and no result without an item
    a_pending: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pending != 2'd3 && (!i_out_valid || r_pending != 2'd0))
        else $error("items and results out of step");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_done)
            && $stable(i_out_freq) && $stable(i_out_cycles) && $stable(i_out_cal))
        else $error("stalled result changed");

endmodule

bind median_clock_frequency_estimator_core mcfe_chk u_mcfe_chk (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_in_valid   (i_in.valid),
    .i_in_ready   (i_in.ready),
    .i_out_valid  (o_out.valid),
    .i_out_ready  (o_out.ready),
    .i_out_done   (o_out.calibration_done),
    .i_out_freq   (o_out.freq_hz),
    .i_out_cycles (o_out.cycles),
    .i_out_cal    (o_out.calibrated)
);

>>> tb/median_clock_frequency_estimator_core_check.sv
`timescale 1ns / 1ps
module median_clock_frequency_estimator_core_check #(
    parameter int NUM_SAMPLES = mcfe_pkg::NUM_SAMPLES_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic                        pready,
    input  logic [mcfe_pkg::ADDR_W-1:0] paddr,
    input  logic [mcfe_pkg::DATA_W-1:0] pwdata,
    mcfe_in_if                          i_in,
    mcfe_out_if                         i_out,
    output int                          o_fail_count,
    output int                          o_pending
);

    localparam logic [63:0] FREQ_SAT = (64'd1 << mcfe_pkg::FREQ_W) - 64'd1;
    localparam logic [63:0] CYC_SAT  = (64'd1 << mcfe_pkg::CYC_W) - 64'd1;

    typedef struct packed {
        logic                        calibration_done;
        logic [mcfe_pkg::FREQ_W-1:0] freq_hz;
        logic [mcfe_pkg::CYC_W-1:0]  cycles;
        logic                        calibrated;
    } t_reading;

    t_reading                    expected_readings [$];
    t_reading                    want;
    t_reading                    seen;
    logic [mcfe_pkg::BUS_W-1:0]  bus_hz;
    logic [mcfe_pkg::WORK_W-1:0] workload;
    logic [mcfe_pkg::SMP_W-1:0]  elapsed_store [NUM_SAMPLES];
    logic [mcfe_pkg::SMP_W-1:0]  ranked [NUM_SAMPLES];
    logic [mcfe_pkg::SMP_W-1:0]  pick;
    logic [mcfe_pkg::FREQ_W-1:0] freq_est;
    logic                        cal_seen;
    logic [63:0]                 wide;
    int                          fill;
    int                          slot;
    int                          fails = 0;
    int                          waiting = 0;

    assign o_fail_count = fails;
    assign o_pending    = waiting;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            bus_hz   = mcfe_pkg::BUS_HZ_RST;
            workload = mcfe_pkg::WORK_RST;
            freq_est = mcfe_pkg::FREQ_RST;
            cal_seen = 1'b0;
            fill     = 0;
            expected_readings.delete();
        end else begin
            if (psel && penable && pwrite && pready) begin
                case (paddr[2])
                    mcfe_pkg::REG_BUS_HZ: bus_hz   = pwdata[mcfe_pkg::BUS_W-1:0];
                    mcfe_pkg::REG_WORK:   workload = pwdata[mcfe_pkg::WORK_W-1:0];
                    default: ;
                endcase
            end

            if (i_out.valid && i_out.ready) begin
                seen.calibration_done = i_out.calibration_done;
                seen.freq_hz          = i_out.freq_hz;
                seen.cycles           = i_out.cycles;
                seen.calibrated       = i_out.calibrated;
                if (expected_readings.size() == 0) begin
                    $error("result with nothing pending: freq_hz %0d, cycles %0d",
                           seen.freq_hz, seen.cycles);
                    fails++;
                end else begin
                    want = expected_readings.pop_front();
                    if (seen.calibration_done !== want.calibration_done) begin
                        $error("calibration_done: expected %0d, got %0d",
                               want.calibration_done, seen.calibration_done);
                        fails++;
                    end
                    if (seen.freq_hz !== want.freq_hz) begin
                        $error("freq_hz: expected %0d, got %0d", want.freq_hz, seen.freq_hz);
                        fails++;
                    end
                    if (seen.cycles !== want.cycles) begin
                        $error("cycles: expected %0d, got %0d", want.cycles, seen.cycles);
                        fails++;
                    end
                    if (seen.calibrated !== want.calibrated) begin
                        $error("calibrated: expected %0d, got %0d",
                               want.calibrated, seen.calibrated);
                        fails++;
                    end
                end
            end

            if (i_in.valid && i_in.ready) begin
                want.calibration_done = 1'b0;
                want.cycles           = '0;
                if (i_in.op == mcfe_pkg::OP_SAMPLE) begin
                    elapsed_store[fill] = 16'hFFFF - i_in.count;
                    fill++;
                    if (fill >= NUM_SAMPLES) begin
                        ranked = elapsed_store;
                        // insertion sort, then the upper median
                        for (int i = 1; i < NUM_SAMPLES; i++) begin
                            pick = ranked[i];
                            slot = i;
                            while (slot > 0 && ranked[slot-1] > pick) begin
                                ranked[slot] = ranked[slot-1];
                                slot--;
                            end
                            ranked[slot] = pick;
                        end
                        pick = ranked[NUM_SAMPLES/2];
                        // zero median falls back to 1 ms without the 0.95 factor
                        if (pick == '0) begin
                            wide = 64'(workload) * 64'd1000;
                        end else begin
                            wide = (64'(workload) * 64'(bus_hz) * 64'd2) / (64'd19 * 64'(pick));
                        end
                        freq_est = (wide > FREQ_SAT) ? FREQ_SAT[mcfe_pkg::FREQ_W-1:0]
                                                     : wide[mcfe_pkg::FREQ_W-1:0];
                        cal_seen = 1'b1;
                        fill     = 0;
                        want.calibration_done = 1'b1;
                    end
                end else begin
                    wide = 64'(i_in.count) * 64'd10 * 64'(freq_est);
                    if (bus_hz == '0) begin
                        want.cycles = (wide == 64'd0) ? '0 : '1;
                    end else begin
                        wide = wide / 64'(bus_hz);
                        want.cycles = (wide > CYC_SAT) ? '1 : wide[mcfe_pkg::CYC_W-1:0];
                    end
                end
                want.freq_hz    = freq_est;
                want.calibrated = cal_seen;
                expected_readings.push_back(want);
            end
        end
        waiting = expected_readings.size();
    end

endmodule

>>> tb/median_clock_frequency_estimator_core_tb.sv
`timescale 1ns / 1ps
module median_clock_frequency_estimator_core_tb;

    localparam int   PHASES       = 8;
    localparam int   PHASE_ITEMS  = 54;
    localparam int   CALM_ITEMS   = 40;
    localparam int   STALL_LIMIT  = 1000;
    localparam int   DRAIN_CYCLES = 80;

    // wide spread of elapsed values, median well away from zero
    localparam logic [mcfe_pkg::SMP_W-1:0] SPREAD_SET [8] = '{
        16'h0000, 16'hFFFF, 16'h8000, 16'h7FFF, 16'h5555, 16'hAAAA, 16'h0001, 16'hFFFE};
    // five full counts, so the median elapsed is zero
    localparam logic [mcfe_pkg::SMP_W-1:0] ZERO_SET [8]   = '{
        16'hFFFF, 16'h0000, 16'hFFFF, 16'h03E8, 16'hFFFF, 16'hFFFF, 16'h9C40, 16'hFFFF};

    logic                        i_clk = 1'b0;
    logic                        i_rst_n = 1'b0;
    logic                        psel;
    logic                        penable;
    logic                        pwrite;
    logic [mcfe_pkg::ADDR_W-1:0] paddr;
    logic [mcfe_pkg::DATA_W-1:0] pwdata;
    logic [mcfe_pkg::DATA_W-1:0] prdata;
    logic                        pready;
    logic                        sink_ready = 1'b0;
    logic                        calm = 1'b0;
    int                          stall_left = 0;
    int                          quiet_cycles = 0;
    int                          fail_count;
    int                          pending;
    int                          n_samples = 0;
    int                          n_converts = 0;
    int                          n_settings = 0;

    mcfe_in_if  in_ch ();
    mcfe_out_if out_ch ();

    assign out_ch.ready = sink_ready;

    median_clock_frequency_estimator_core dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    median_clock_frequency_estimator_core_check u_check (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .pready       (pready),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .i_in         (in_ch),
        .i_out        (out_ch),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // receiver back-pressure in random bursts
    always @(negedge i_clk) begin
        if (!calm && stall_left > 0) begin
            sink_ready <= 1'b0;
            stall_left <= stall_left - 1;
        end else if (!calm && $urandom_range(0, 5) == 0) begin
            sink_ready <= 1'b0;
            stall_left <= $urandom_range(0, 7);
        end else begin
            sink_ready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) || (psel && penable)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    task automatic apb_write(input logic idx, input logic [mcfe_pkg::DATA_W-1:0] data);
        @(negedge i_clk);
        psel    = 1'b1;
        pwrite  = 1'b1;
        penable = 1'b0;
        paddr   = mcfe_pkg::ADDR_W'({idx, 2'b00});
        pwdata  = data;
        @(negedge i_clk);
        penable = 1'b1;
        do @(posedge i_clk); while (!pready);
        @(negedge i_clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
    endtask

    task automatic send_item(input logic op, input logic [mcfe_pkg::SMP_W-1:0] cnt);
        int gap;
        @(negedge i_clk);
        if (!calm && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 8);
            in_ch.valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        in_ch.valid = 1'b1;
        in_ch.op    = op;
        in_ch.count = cnt;
        do @(posedge i_clk); while (!in_ch.ready);
        if (op == mcfe_pkg::OP_SAMPLE) begin
            n_samples++;
        end else begin
            n_converts++;
        end
    endtask

    task automatic drain();
        @(negedge i_clk);
        in_ch.valid = 1'b0;
        while (pending != 0) @(negedge i_clk);
    endtask

    initial begin
        logic [mcfe_pkg::DATA_W-1:0] bus_val;
        logic [mcfe_pkg::DATA_W-1:0] work_val;
        logic                        op;
        logic [mcfe_pkg::SMP_W-1:0]  cnt;
        int                          tilt;
        int                          r;

        psel        = 1'b0;
        penable     = 1'b0;
        pwrite      = 1'b0;
        paddr       = '0;
        pwdata      = '0;
        in_ch.valid = 1'b0;
        in_ch.op    = mcfe_pkg::OP_SAMPLE;
        in_ch.count = '0;
        repeat (2) @(negedge i_clk);
        i_rst_n = 1'b1;

        // converts on the reset estimate, from a zero count up to the full count
        send_item(mcfe_pkg::OP_CONVERT, 16'h0000);
        send_item(mcfe_pkg::OP_CONVERT, 16'h0001);
        send_item(mcfe_pkg::OP_CONVERT, 16'hFFFF);
        for (int i = 0; i < 8; i++) send_item(mcfe_pkg::OP_SAMPLE, SPREAD_SET[i]);
        send_item(mcfe_pkg::OP_CONVERT, 16'h1234);
        for (int i = 0; i < 8; i++) send_item(mcfe_pkg::OP_SAMPLE, ZERO_SET[i]);
        send_item(mcfe_pkg::OP_CONVERT, 16'hFFFF);

        for (int ph = 0; ph < PHASES; ph++) begin
            if (ph > 0) begin
                drain();
                case (ph)
                    1: begin
                        bus_val  = 32'd50000000;
                        work_val = 32'h00FF_FFFF;
                    end
                    2: begin
                        bus_val  = 32'd1000000;
                        work_val = 32'd1;
                    end
                    3: begin
                        bus_val  = 32'd0;
                        work_val = 32'd131072;
                    end
                    4: begin
                        bus_val  = 32'h03FF_FFFF;
                        work_val = 32'h00FF_FFFF;
                    end
                    5: begin
                        bus_val  = 32'd7093790;
                        work_val = 32'd0;
                    end
                    default: begin
                        // upper bits set now and then, the register keeps its own width
                        bus_val  = ($urandom_range(0, 2) == 0) ? $urandom()
                                                               : $urandom_range(1000000, 50000000);
                        work_val = ($urandom_range(0, 2) == 0) ? $urandom()
                                                               : $urandom_range(1, 24'hFFFFFF);
                    end
                endcase
                apb_write(mcfe_pkg::REG_BUS_HZ, bus_val);
                apb_write(mcfe_pkg::REG_WORK, work_val);
                n_settings++;
            end

            // largest settings with tiny elapsed values push the estimate into saturation
            tilt = (ph == 4) ? 1 : $urandom_range(0, 2);
            for (int k = 0; k < PHASE_ITEMS; k++) begin
                calm = (ph == PHASES - 1) && (k >= PHASE_ITEMS - CALM_ITEMS);
                op   = ($urandom_range(0, 3) == 0) ? mcfe_pkg::OP_CONVERT : mcfe_pkg::OP_SAMPLE;
                r    = $urandom_range(0, 9);
                case (tilt)
                    1: cnt = (r < 7) ? 16'hFFFF - mcfe_pkg::SMP_W'($urandom_range(0, 3))
                                     : mcfe_pkg::SMP_W'($urandom());
                    2: cnt = mcfe_pkg::SMP_W'($urandom());
                    default: begin
                        if (r == 0) begin
                            cnt = 16'hFFFF;
                        end else if (r == 1) begin
                            cnt = 16'h0000;
                        end else if (r < 4) begin
                            cnt = 16'hFFFF - mcfe_pkg::SMP_W'($urandom_range(0, 31));
                        end else begin
                            cnt = mcfe_pkg::SMP_W'($urandom());
                        end
                    end
                endcase
                send_item(op, cnt);
            end
        end

        drain();
        repeat (DRAIN_CYCLES) @(negedge i_clk);
        $display("%0d items sent: %0d timer samples, %0d tick conversions",
                 n_samples + n_converts, n_samples, n_converts);
        $display("%0d register settings applied after the reset defaults", n_settings);
        if (fail_count == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule

>>> files.f
rtl/mcfe_pkg.sv
rtl/mcfe_in_if.sv
rtl/mcfe_out_if.sv
rtl/mcfe_cfg.sv
rtl/mcfe_div.sv
rtl/mcfe_dp.sv
rtl/mcfe_ctrl.sv
rtl/median_clock_frequency_estimator_core.sv
rtl/mcfe_chk.sv
tb/median_clock_frequency_estimator_core_check.sv
tb/median_clock_frequency_estimator_core_tb.sv
